[design/mep_pkg.sv]
package mep_pkg;

  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned OPND_W    = 33;
  localparam int unsigned PROD_W    = 2 * OPND_W;

  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // three operand pairs, one per multiplier lane
  typedef struct packed {
    opnd_t a0;
    opnd_t b0;
    opnd_t a1;
    opnd_t b1;
    opnd_t a2;
    opnd_t b2;
  } mul_req_t;

  typedef struct packed {
    prod_t p0;
    prod_t p1;
    prod_t p2;
  } mul_rsp_t;

  // register indexes on the configuration port
  localparam logic [2:0] REG_REAL_ORIGIN = 3'd0;
  localparam logic [2:0] REG_IMAG_ORIGIN = 3'd1;
  localparam logic [2:0] REG_REAL_STEP   = 3'd2;
  localparam logic [2:0] REG_IMAG_STEP   = 3'd3;
  localparam logic [2:0] REG_HEIGHT      = 3'd4;
  localparam logic [2:0] REG_ITER_LIMIT  = 3'd5;
  localparam logic [2:0] REG_COLOR_BASE  = 3'd6;
  localparam logic [2:0] REG_COLOR_STEP  = 3'd7;

  // |z|^2 escape bound, 4.0 at product scale
  localparam logic [PROD_W-1:0] MAG_BOUND = PROD_W'(4) << (2 * FRAC_BITS);

  function automatic logic signed [31:0] sat32(input prod_t x);
    logic [PROD_W-32:0] hi;
    hi = x[PROD_W-1:31];
    if (hi == '0 || hi == '1) begin
      return x[31:0];
    end else if (x[PROD_W-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

endpackage

[design/mandelbrot_escape_pixel_unit.sv]
// Escape-time pixel unit: one pixel per start transfer, result strobed for one cycle.
// Steps: after the accepting edge the unit runs S_CMUL and S_CADD, then S_ZMUL and S_ZUPD in
// turn until finish, then S_KMUL and S_COLR; result_valid_o is registered from S_COLR and busy_o
// is high in every state but S_IDLE. A new start is taken in the strobe cycle and the receiver
// cannot stall. Each z iteration is one pass through the shared multiplier.
// Reset: asynchronous, active low; returns to idle and loads default view registers.
module mandelbrot_escape_pixel_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [11:0] column_i,
  input  logic [11:0] row_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [11:0] pixel_column_o,
  output logic [11:0] pixel_row_o,
  output logic [15:0] iteration_count_o,
  output logic [23:0] pixel_color_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b000_0001,
    S_CMUL = 7'b000_0010,
    S_CADD = 7'b000_0100,
    S_ZMUL = 7'b000_1000,
    S_ZUPD = 7'b001_0000,
    S_KMUL = 7'b010_0000,
    S_COLR = 7'b100_0000
  } state_e;

  state_e state_q, state_d;
  logic   valid_q;

  logic signed [31:0] real_origin_q, imag_origin_q;
  logic [30:0]        real_step_q, imag_step_q;
  logic [12:0]        height_q;
  logic [15:0]        limit_q;
  logic [23:0]        color_base_q;
  logic [31:0]        color_step_q;

  logic [11:0]        col_q, row_q;
  logic signed [31:0] cr_q, ci_q, zr_q, zi_q;
  logic [15:0]        k_q;
  logic [23:0]        color_q;

  mep_pkg::mul_req_t  mul_req;
  mep_pkg::mul_rsp_t  mul_rsp;

  logic               accept;
  logic signed [14:0] flip;
  mep_pkg::prod_t     cr_sum, ci_sum;
  mep_pkg::prod_t     rdiff, rdiff_sh, ri_sh, nr_sum, ni_sum;
  logic [mep_pkg::PROD_W-1:0] mag;
  logic [15:0]        limit_eff;
  logic               finish;
  logic [32:0]        color_sum;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_origin_q <= -32'sd536870912;
      imag_origin_q <= -32'sd536870912;
      real_step_q   <= 31'd1342177;
      imag_step_q   <= 31'd1342177;
      height_q      <= 13'd800;
      limit_q       <= 16'd256;
      color_base_q  <= 24'd0;
      color_step_q  <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mep_pkg::REG_REAL_ORIGIN: real_origin_q <= cfg_data_i;
        mep_pkg::REG_IMAG_ORIGIN: imag_origin_q <= cfg_data_i;
        mep_pkg::REG_REAL_STEP:   real_step_q   <= cfg_data_i[30:0];
        mep_pkg::REG_IMAG_STEP:   imag_step_q   <= cfg_data_i[30:0];
        mep_pkg::REG_HEIGHT:      height_q      <= cfg_data_i[12:0];
        mep_pkg::REG_ITER_LIMIT:  limit_q       <= cfg_data_i[15:0];
        mep_pkg::REG_COLOR_BASE:  color_base_q  <= cfg_data_i[23:0];
        mep_pkg::REG_COLOR_STEP:  color_step_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // height-1-row, negative when the row lies outside the image
  assign flip = $signed({2'b00, height_q}) - 15'sd1 - $signed({3'b000, row_q});

  // operand selection for the shared multiplier
  always_comb begin
    mul_req = '0;
    unique case (state_q)
      S_CMUL: begin
        mul_req.a0 = {21'b0, col_q};
        mul_req.b0 = {2'b0, real_step_q};
        mul_req.a1 = {{18{flip[14]}}, flip};
        mul_req.b1 = {2'b0, imag_step_q};
      end
      S_ZMUL: begin
        mul_req.a0 = {zr_q[31], zr_q};
        mul_req.b0 = {zr_q[31], zr_q};
        mul_req.a1 = {zi_q[31], zi_q};
        mul_req.b1 = {zi_q[31], zi_q};
        mul_req.a2 = {zr_q[31], zr_q};
        mul_req.b2 = {zi_q[31], zi_q};
      end
      S_KMUL: begin
        mul_req.a0 = {17'b0, k_q - 16'd1};
        mul_req.b0 = {1'b0, color_step_q};
      end
      default: ;
    endcase
  end

  mep_mul_unit u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  // point c from the registered offsets
  assign cr_sum = {{34{real_origin_q[31]}}, real_origin_q} + mul_rsp.p0;
  assign ci_sum = {{34{imag_origin_q[31]}}, imag_origin_q} + mul_rsp.p1;

  // z update; arithmetic shifts give the floored divide
  assign rdiff    = mul_rsp.p0 - mul_rsp.p1;
  assign rdiff_sh = rdiff >>> mep_pkg::FRAC_BITS;
  assign ri_sh    = mul_rsp.p2 >>> (mep_pkg::FRAC_BITS - 1);
  assign nr_sum   = rdiff_sh + {{34{cr_q[31]}}, cr_q};
  assign ni_sum   = ri_sh + {{34{ci_q[31]}}, ci_q};

  // products here belong to the z left by the previous update
  assign mag       = mul_rsp.p0 + mul_rsp.p1;
  assign limit_eff = (limit_q == '0) ? 16'd1 : limit_q;
  assign finish    = (k_q != '0) && ((mag >= mep_pkg::MAG_BOUND) || (k_q >= limit_eff));

  assign color_sum = {9'b0, color_base_q} + {1'b0, mul_rsp.p0[47:16]};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_CMUL;
      S_CMUL: state_d = S_CADD;
      S_CADD: state_d = S_ZMUL;
      S_ZMUL: state_d = S_ZUPD;
      S_ZUPD: state_d = finish ? S_KMUL : S_ZMUL;
      S_KMUL: state_d = S_COLR;
      S_COLR: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == S_COLR);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q <= column_i;
      row_q <= row_i;
    end
    unique case (state_q)
      S_CADD: begin
        cr_q <= mep_pkg::sat32(cr_sum);
        ci_q <= mep_pkg::sat32(ci_sum);
        zr_q <= '0;
        zi_q <= '0;
        k_q  <= '0;
      end
      S_ZUPD: begin
        if (!finish) begin
          zr_q <= mep_pkg::sat32(nr_sum);
          zi_q <= mep_pkg::sat32(ni_sum);
          k_q  <= k_q + 16'd1;
        end
      end
      S_COLR: color_q <= (color_sum[32:24] != '0) ? 24'hFF_FFFF : color_sum[23:0];
      default: ;
    endcase
  end

  assign result_valid_o    = valid_q;
  assign pixel_column_o    = col_q;
  assign pixel_row_o       = row_q;
  assign iteration_count_o = k_q;
  assign pixel_color_o     = color_q;

endmodule

[design/mep_mul_unit.sv]
module mep_mul_unit (
  input  logic             clk_i,
  input  mep_pkg::mul_req_t req_i,
  output mep_pkg::mul_rsp_t rsp_o
);

  mep_pkg::mul_rsp_t rsp_q;

  always_ff @(posedge clk_i) begin
    rsp_q.p0 <= $signed(req_i.a0) * $signed(req_i.b0);
    rsp_q.p1 <= $signed(req_i.a1) * $signed(req_i.b1);
    rsp_q.p2 <= $signed(req_i.a2) * $signed(req_i.b2);
  end

  assign rsp_o = rsp_q;

endmodule

[design/mep_chk.sv]
module mep_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        result_valid_o,
  input logic [15:0] iteration_count_o
);

  // a pixel passes through every state from S_CMUL to S_COLR, so strobes never abut
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !result_valid_o))
    else $error("accepted transfer did not start work");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result strobed while still busy");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (iteration_count_o != 16'd0))
    else $error("iteration count of zero reported");

  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result strobed without preceding work");

endmodule

bind mandelbrot_escape_pixel_unit mep_chk u_mep_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .result_valid_o    (result_valid_o),
  .iteration_count_o (iteration_count_o)
);
